@@ hdl/lcdfb_pkg.sv @@
package lcdfb_pkg;

    localparam int ModeW = 3;
    localparam int ByteW = 8;
    localparam int CfgIdxW = 3;

    // Item modes.
    localparam logic [ModeW-1:0] MODE_BEGIN = 3'd0;
    localparam logic [ModeW-1:0] MODE_BLOCK = 3'd1;
    localparam logic [ModeW-1:0] MODE_PIXEL = 3'd2;
    localparam logic [ModeW-1:0] MODE_HOLD  = 3'd3;
    localparam logic [ModeW-1:0] MODE_CLEAR = 3'd4;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_UPDATE_HI = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_UPDATE_LO = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_HOLD_HI   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_HOLD_LO   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_CLEAR_HI  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_CLEAR_LO  = 3'd5;

    typedef struct packed {
        logic [ByteW-1:0] update_hi;
        logic [ByteW-1:0] update_lo;
        logic [ByteW-1:0] hold_hi;
        logic [ByteW-1:0] hold_lo;
        logic [ByteW-1:0] clear_hi;
        logic [ByteW-1:0] clear_lo;
    } t_codes;

    // Up to three bytes caused by one item, first byte in b0.
    typedef struct packed {
        logic [1:0]       count;
        logic [ByteW-1:0] b0;
        logic [ByteW-1:0] b1;
        logic [ByteW-1:0] b2;
    } t_burst;

endpackage

@@ hdl/lcdfb_engine.sv @@
module lcdfb_engine #(
    parameter int LINE_PIXELS = 176
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [lcdfb_pkg::ModeW-1:0]  i_mode,
    input  logic [lcdfb_pkg::ByteW-1:0]  i_start_row,
    input  logic [lcdfb_pkg::ByteW-1:0]  i_pixel,
    input  lcdfb_pkg::t_codes            i_codes,
    output lcdfb_pkg::t_burst            o_burst
);

    localparam logic [7:0] LineEnd = 8'(LINE_PIXELS);

    logic [7:0] r_row;
    logic       r_phase;
    logic [7:0] r_pos;
    logic [7:0] r_partial;
    logic [7:0] n_row;
    logic       n_phase;
    logic [7:0] n_pos;
    logic [7:0] n_partial;

    logic [2:0] held;
    logic [3:0] total;
    logic       full;
    logic [1:0] rest;
    logic [7:0] held_mask;
    logic [7:0] kept;
    logic [2:0] colour;
    logic [9:0] comb_bits;
    logic [7:0] packed_byte;
    logic [7:0] pos_inc;
    logic       eol;
    logic [7:0] row_inc;
    logic       phase_t;

    // Three bits per pixel: the bits already held wrap through 0,3,6,1,4,7,2,5.
    assign held        = r_pos[2:0] + {r_pos[1:0], 1'b0};
    assign total       = {1'b0, held} + 4'd3;
    assign full        = total[3];
    assign rest        = total[1:0];
    assign held_mask   = 8'((16'd1 << held) - 16'd1);
    assign kept        = r_partial & held_mask;
    assign colour      = {i_pixel[7], i_pixel[4], i_pixel[1]};
    assign comb_bits   = {kept[6:0], colour};
    assign packed_byte = 8'(comb_bits >> rest);
    assign pos_inc     = r_pos + 8'd1;
    assign eol         = (pos_inc >= LineEnd);
    assign row_inc     = r_row + 8'd1;
    assign phase_t     = ~r_phase;

    always_comb begin
        n_row     = r_row;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_partial = r_partial;
        o_burst   = '0;
        unique case (i_mode)
            lcdfb_pkg::MODE_BEGIN: begin
                n_row = i_start_row + 8'd1;
            end
            lcdfb_pkg::MODE_BLOCK: begin
                n_phase       = phase_t;
                n_pos         = '0;
                n_partial     = '0;
                o_burst.count = 2'd2;
                o_burst.b0    = phase_t ? i_codes.update_hi : i_codes.update_lo;
                o_burst.b1    = r_row;
            end
            lcdfb_pkg::MODE_PIXEL: begin
                if (full) begin
                    n_partial = 8'(comb_bits & ((10'd1 << rest) - 10'd1));
                end else begin
                    n_partial = comb_bits[7:0];
                end
                n_pos = pos_inc;
                if (eol) begin
                    n_pos     = '0;
                    n_partial = '0;
                    n_row     = row_inc;
                end
                if (full && eol) begin
                    o_burst.count = 2'd3;
                    o_burst.b0    = packed_byte;
                    o_burst.b1    = '0;
                    o_burst.b2    = row_inc;
                end else if (full) begin
                    o_burst.count = 2'd1;
                    o_burst.b0    = packed_byte;
                end else if (eol) begin
                    o_burst.count = 2'd2;
                    o_burst.b0    = '0;
                    o_burst.b1    = row_inc;
                end
            end
            lcdfb_pkg::MODE_HOLD: begin
                n_phase       = phase_t;
                o_burst.count = 2'd2;
                o_burst.b0    = phase_t ? i_codes.hold_hi : i_codes.hold_lo;
                o_burst.b1    = '0;
            end
            lcdfb_pkg::MODE_CLEAR: begin
                n_phase       = phase_t;
                o_burst.count = 2'd2;
                o_burst.b0    = phase_t ? i_codes.clear_hi : i_codes.clear_lo;
                o_burst.b1    = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_phase   <= 1'b0;
            r_pos     <= '0;
            r_partial <= '0;
        end else if (i_accept) begin
            r_row     <= n_row;
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_partial <= n_partial;
        end
    end

endmodule

@@ hdl/lcdfb_burst_buf.sv @@
module lcdfb_burst_buf (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  lcdfb_pkg::t_burst            i_burst,
    input  logic                         i_out_ready,
    output logic                         o_can_load,
    output logic                         o_out_valid,
    output logic [lcdfb_pkg::ByteW-1:0]  o_out_byte,
    output logic                         o_last_of_run
);

    logic [1:0]                    r_cnt;
    logic [lcdfb_pkg::ByteW-1:0]   r_b0;
    logic [lcdfb_pkg::ByteW-1:0]   r_b1;
    logic [lcdfb_pkg::ByteW-1:0]   r_b2;
    logic                          take;

    assign o_out_valid   = (r_cnt != 2'd0);
    assign o_out_byte    = r_b0;
    assign o_last_of_run = (r_cnt == 2'd1);
    assign take          = o_out_valid && i_out_ready;
    // Room for a new burst once the last waiting byte leaves this cycle.
    assign o_can_load    = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b0 <= i_burst.b0;
            r_b1 <= i_burst.b1;
            r_b2 <= i_burst.b2;
        end else if (take) begin
            r_b0 <= r_b1;
            r_b1 <= r_b2;
        end
    end

endmodule

@@ hdl/memory_lcd_line_frame_builder_core.sv @@
// The first byte of an item appears in the cycle after the item is accepted, from the burst buffer register.
// One item is accepted per cycle while each item causes at most one byte and the output is ready; an
// item that causes two or three bytes holds the input until its last byte leaves the output port.
// The output port delivers one byte per cycle while i_out_ready is high, from the three-byte burst buffer.
// Reset (synchronous, active low) clears row address, COM phase and packing state, empties
// the buffer and loads the default command codes.
module memory_lcd_line_frame_builder_core #(
    parameter int LINE_PIXELS = 176
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Item input channel.
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [lcdfb_pkg::ModeW-1:0]    i_mode,
    input  logic [lcdfb_pkg::ByteW-1:0]    i_start_row,
    input  logic [lcdfb_pkg::ByteW-1:0]    i_pixel,
    // Byte output channel.
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lcdfb_pkg::ByteW-1:0]    o_out_byte,
    output logic                           o_last_of_run,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [lcdfb_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [lcdfb_pkg::ByteW-1:0]    i_cfg_data
);

    lcdfb_pkg::t_codes r_codes;
    lcdfb_pkg::t_burst burst;
    logic              can_load;
    logic              in_accept;
    logic              load;

    // An item is taken whenever the burst buffer is empty or empties this cycle.
    // Items that cause no byte (begin frame, a pixel that neither fills a byte nor
    // ends the line) only update the state; unknown modes change nothing.
    assign o_in_ready = can_load;
    assign in_accept  = i_in_valid && can_load;
    assign load       = in_accept && (burst.count != 2'd0);

    // Command code registers; writes to indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.update_hi <= 8'd192;
            r_codes.update_lo <= 8'd128;
            r_codes.hold_hi   <= 8'd64;
            r_codes.hold_lo   <= 8'd0;
            r_codes.clear_hi  <= 8'd96;
            r_codes.clear_lo  <= 8'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lcdfb_pkg::REG_UPDATE_HI: r_codes.update_hi <= i_cfg_data;
                lcdfb_pkg::REG_UPDATE_LO: r_codes.update_lo <= i_cfg_data;
                lcdfb_pkg::REG_HOLD_HI:   r_codes.hold_hi   <= i_cfg_data;
                lcdfb_pkg::REG_HOLD_LO:   r_codes.hold_lo   <= i_cfg_data;
                lcdfb_pkg::REG_CLEAR_HI:  r_codes.clear_hi  <= i_cfg_data;
                lcdfb_pkg::REG_CLEAR_LO:  r_codes.clear_lo  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Packing, row and phase state, and the bytes each item causes.
    lcdfb_engine #(
        .LINE_PIXELS (LINE_PIXELS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_mode      (i_mode),
        .i_start_row (i_start_row),
        .i_pixel     (i_pixel),
        .i_codes     (r_codes),
        .o_burst     (burst)
    );

    // Holds the burst and hands it out one byte per cycle while the output is ready.
    lcdfb_burst_buf u_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_burst       (burst),
        .i_out_ready   (i_out_ready),
        .o_can_load    (can_load),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule
